// ===== hw/rtl/rsfs_pkg.sv =====
// Shared types, constants and helpers for the record slot store.
package rsfs_pkg;

	// Default sizes
	localparam int unsigned SLOT_COUNT_DEF       = 32;
	localparam int unsigned FREE_STACK_DEPTH_DEF = 16;
	localparam int unsigned RECENT_DEPTH_DEF     = 10;

	// Erased contents
	localparam logic [63:0] ERASED_WORD = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [7:0]  ERASED_BYTE = 8'hFF;

	// Command modes
	localparam logic [2:0] MODE_STORE  = 3'd0;
	localparam logic [2:0] MODE_DELETE = 3'd1;
	localparam logic [2:0] MODE_READ   = 3'd2;
	localparam logic [2:0] MODE_RESET  = 3'd3;
	localparam logic [2:0] MODE_RECENT = 3'd4;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_FULL       = 3'd1,
		ST_ERASED     = 3'd2,
		ST_STACK_FULL = 3'd3,
		ST_RANGE      = 3'd4
	} status_t;

	// Command item
	typedef struct packed {
		logic [2:0]  mode;
		logic [7:0]  slot_index;
		logic [63:0] record_in;
	} cmd_t;

	// Result item
	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  slot_used;
		logic [63:0] record_out;
		logic [5:0]  live_count;
		logic [4:0]  recent_count;
	} rsp_t;

	// Address bits for a store of n entries, at least one
	function automatic int unsigned addr_w(input int unsigned n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	// Bits for a count from 0 to n inclusive
	function automatic int unsigned count_w(input int unsigned n);
		return $clog2(n + 1);
	endfunction

endpackage

// ===== hw/rtl/rsfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rsfs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [rsfs_pkg::addr_w(DEPTH)-1:0]     waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [rsfs_pkg::addr_w(DEPTH)-1:0]     raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/record_slot_store_with_free_stack_top.sv =====
// Top level of the record slot store with free stack and recent-slots list.
//
// One command channel (cmd_valid / cmd_stall / cmd) and one result channel
// (rsp_valid / rsp_stall / rsp). Every command item gives exactly one result item.
// Commands: store a record into the last freed slot (or the next fresh one),
// delete a slot, read a slot, erase everything, read a recent-list entry.
// One command is worked on at a time; cmd_stall is high from acceptance until
// the result has been moved into the output register, and the next item can be
// accepted once the sequencer is back in its idle state.
// Errors found at decode, reset-all and unused modes go from decode straight to
// the finish state; a read slot passes a read-data state, a refused delete a
// check state, a store a store state (after a pop state when it takes a slot
// from the free stack), a read recent a list state and a record state. A delete
// that succeeds, and a store into a full list, also sweep the recent list: it is
// shifted through its RAM one entry per cycle.
// Records, free stack and recent list sit in three RAMs; a valid bit per slot
// marks live contents, so an erased slot reads as all ones with no clearing pass.
// Reset (arst_n low) and reset-all clear the valid bits and counters at once.
// While rsp_stall is high the result waits in the output register; a next item
// is accepted meanwhile and its result waits internally until the register frees.
module record_slot_store_with_free_stack_top #(
	parameter int unsigned SLOT_COUNT       = rsfs_pkg::SLOT_COUNT_DEF,
	parameter int unsigned FREE_STACK_DEPTH = rsfs_pkg::FREE_STACK_DEPTH_DEF,
	parameter int unsigned RECENT_DEPTH     = rsfs_pkg::RECENT_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  rsfs_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output rsfs_pkg::rsp_t rsp
);

	localparam int unsigned SW  = rsfs_pkg::addr_w(SLOT_COUNT);
	localparam int unsigned LW  = rsfs_pkg::count_w(SLOT_COUNT);
	localparam int unsigned FAW = rsfs_pkg::addr_w(FREE_STACK_DEPTH);
	localparam int unsigned FCW = rsfs_pkg::count_w(FREE_STACK_DEPTH);
	localparam int unsigned RAW = rsfs_pkg::addr_w(RECENT_DEPTH);
	localparam int unsigned RCW = rsfs_pkg::count_w(RECENT_DEPTH);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_DECODE = 10'b00_0000_0010,
		S_POP    = 10'b00_0000_0100,
		S_STORE  = 10'b00_0000_1000,
		S_CHECK  = 10'b00_0001_0000,
		S_SWEEP  = 10'b00_0010_0000,
		S_RDATA  = 10'b00_0100_0000,
		S_RLIST  = 10'b00_1000_0000,
		S_RREC   = 10'b01_0000_0000,
		S_FINISH = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	// Control state
	logic [SLOT_COUNT-1:0] vld_q;
	logic [LW-1:0]         live_q;
	logic [FCW-1:0]        fdepth_q;
	logic [RCW-1:0]        rused_q;
	logic [RCW-1:0]        rp_q;
	logic                  found_q;
	logic                  dv_s1;
	logic                  rsp_valid_q;

	// Payload registers
	logic [2:0]        mode_q;
	logic [7:0]        idx_q;
	logic [63:0]       rec_q;
	rsfs_pkg::status_t st_q;
	logic [SW-1:0]     slot_q;
	logic [63:0]       rout_q;
	logic [RAW-1:0]    pos_s1;
	rsfs_pkg::rsp_t    rsp_q;

	// RAM ports
	logic            rec_we;
	logic [SW-1:0]   rec_waddr;
	logic [SW-1:0]   rec_raddr;
	logic [63:0]     rec_rd;
	logic            fs_we;
	logic [FAW-1:0]  fs_waddr;
	logic [FAW-1:0]  fs_raddr;
	logic [SW-1:0]   fs_rd;
	logic            rl_we;
	logic [RAW-1:0]  rl_waddr;
	logic [SW-1:0]   rl_wdata;
	logic [RAW-1:0]  rl_raddr;
	logic [SW-1:0]   rl_rd;

	// Decode helpers
	logic           accept;
	logic           load;
	logic           idx_range;
	logic           store_full;
	logic           fs_empty;
	logic           fs_full;
	logic           rl_full;
	logic [FCW-1:0] fdm1;
	logic           pop_bad;
	logic           del_erased;
	logic           del_ok;
	logic           rl_slot_ok;
	logic           rec_live;
	logic           sw_issue;
	logic           sw_done;
	logic [8:0]     live9;
	logic [7:0]     slot8;

	assign accept     = cmd_valid && (state_q == S_IDLE);
	assign cmd_stall  = (state_q != S_IDLE);
	assign load       = (state_q == S_FINISH) && (!rsp_valid_q || !rsp_stall);
	assign idx_range  = ({1'b0, idx_q} >= 9'(SLOT_COUNT));
	assign store_full = (live_q >= LW'(SLOT_COUNT));
	assign fs_empty   = (fdepth_q == '0);
	assign fs_full    = (fdepth_q == FCW'(FREE_STACK_DEPTH));
	assign rl_full    = (rused_q == RCW'(RECENT_DEPTH));
	assign fdm1       = fdepth_q - FCW'(1);
	assign pop_bad    = ({1'b0, fs_rd} >= (SW + 1)'(SLOT_COUNT));
	assign del_erased = !vld_q[idx_q[SW-1:0]] || (rec_rd[7:0] == rsfs_pkg::ERASED_BYTE);
	assign del_ok     = !del_erased && !fs_full;
	assign rl_slot_ok = ({1'b0, rl_rd} < (SW + 1)'(SLOT_COUNT));
	assign rec_live   = vld_q[slot_q];
	assign sw_issue   = (rp_q < rused_q);
	assign sw_done    = !sw_issue && !dv_s1;

	// Record memory port control
	always_comb begin
		rec_we    = (state_q == S_STORE);
		rec_waddr = slot_q;
		rec_raddr = idx_q[SW-1:0];
		if (state_q == S_RLIST) begin
			rec_raddr = rl_rd;
		end
	end

	// Free stack port control
	always_comb begin
		fs_we    = (state_q == S_CHECK) && del_ok;
		fs_waddr = fdepth_q[FAW-1:0];
		fs_raddr = fdm1[FAW-1:0];
	end

	// Recent list port control: append, or one shift step per cycle
	always_comb begin
		rl_we    = 1'b0;
		rl_waddr = rused_q[RAW-1:0];
		rl_wdata = slot_q;
		rl_raddr = idx_q[RAW-1:0];
		if (state_q == S_STORE) begin
			rl_we = !rl_full;
		end
		if (state_q == S_SWEEP) begin
			rl_raddr = rp_q[RAW-1:0];
			if (dv_s1 && found_q) begin
				rl_we    = 1'b1;
				rl_waddr = pos_s1 - RAW'(1);
				rl_wdata = rl_rd;
			end else if (sw_done && (mode_q == rsfs_pkg::MODE_STORE)) begin
				rl_we    = 1'b1;
				rl_waddr = RAW'(RECENT_DEPTH - 1);
			end
		end
	end

	rsfs_ram #(.WIDTH(64), .DEPTH(SLOT_COUNT)) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_waddr),
		.wdata (rec_q),
		.raddr (rec_raddr),
		.rdata (rec_rd)
	);

	rsfs_ram #(.WIDTH(SW), .DEPTH(FREE_STACK_DEPTH)) u_fs_ram (
		.clk   (clk),
		.we    (fs_we),
		.waddr (fs_waddr),
		.wdata (idx_q[SW-1:0]),
		.raddr (fs_raddr),
		.rdata (fs_rd)
	);

	rsfs_ram #(.WIDTH(SW), .DEPTH(RECENT_DEPTH)) u_rl_ram (
		.clk   (clk),
		.we    (rl_we),
		.waddr (rl_waddr),
		.wdata (rl_wdata),
		.raddr (rl_raddr),
		.rdata (rl_rd)
	);

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vld_q       <= '0;
			live_q      <= '0;
			fdepth_q    <= '0;
			rused_q     <= '0;
			rp_q        <= '0;
			found_q     <= 1'b0;
			dv_s1       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			dv_s1 <= (state_q == S_SWEEP) && sw_issue;
			// result register: filled on load, emptied when taken
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					unique case (mode_q)
						rsfs_pkg::MODE_STORE: begin
							if (store_full) begin
								state_q <= S_FINISH;
							end else if (!fs_empty) begin
								fdepth_q <= fdm1;
								state_q  <= S_POP;
							end else begin
								state_q <= S_STORE;
							end
						end
						rsfs_pkg::MODE_DELETE: begin
							state_q <= idx_range ? S_FINISH : S_CHECK;
						end
						rsfs_pkg::MODE_READ: begin
							state_q <= idx_range ? S_FINISH : S_RDATA;
						end
						rsfs_pkg::MODE_RESET: begin
							vld_q    <= '0;
							live_q   <= '0;
							fdepth_q <= '0;
							rused_q  <= '0;
							state_q  <= S_FINISH;
						end
						rsfs_pkg::MODE_RECENT: begin
							state_q <= (idx_q < 8'(rused_q)) ? S_RLIST : S_FINISH;
						end
						default: begin
							state_q <= S_FINISH;
						end
					endcase
				end
				S_POP: begin
					state_q <= pop_bad ? S_FINISH : S_STORE;
				end
				S_STORE: begin
					vld_q[slot_q] <= 1'b1;
					live_q        <= live_q + LW'(1);
					if (!rl_full) begin
						rused_q <= rused_q + RCW'(1);
						state_q <= S_FINISH;
					end else begin
						// full list: drop the oldest by shifting from position 1
						rp_q    <= RCW'(1);
						found_q <= 1'b1;
						state_q <= S_SWEEP;
					end
				end
				S_CHECK: begin
					if (del_ok) begin
						fdepth_q               <= fdepth_q + FCW'(1);
						vld_q[idx_q[SW-1:0]]   <= 1'b0;
						if (live_q != '0) begin
							live_q <= live_q - LW'(1);
						end
						rp_q    <= '0;
						found_q <= 1'b0;
						state_q <= S_SWEEP;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_SWEEP: begin
					if (sw_issue) begin
						rp_q <= rp_q + RCW'(1);
					end
					if (dv_s1 && !found_q && (rl_rd == slot_q)) begin
						found_q <= 1'b1;
					end
					if (sw_done) begin
						if ((mode_q != rsfs_pkg::MODE_STORE) && found_q) begin
							rused_q <= rused_q - RCW'(1);
						end
						state_q <= S_FINISH;
					end
				end
				S_RDATA: begin
					state_q <= S_FINISH;
				end
				S_RLIST: begin
					state_q <= rl_slot_ok ? S_RREC : S_FINISH;
				end
				S_RREC: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command capture and result fields
	always_ff @(posedge clk) begin
		pos_s1 <= rp_q[RAW-1:0];
		if (accept) begin
			mode_q <= cmd.mode;
			idx_q  <= cmd.slot_index;
			rec_q  <= cmd.record_in;
			st_q   <= rsfs_pkg::ST_OK;
			slot_q <= '0;
			rout_q <= '0;
		end
		case (state_q)
			S_DECODE: begin
				case (mode_q) inside
					rsfs_pkg::MODE_STORE: begin
						if (store_full) begin
							st_q <= rsfs_pkg::ST_FULL;
						end else if (fs_empty) begin
							slot_q <= live_q[SW-1:0];
						end
					end
					rsfs_pkg::MODE_DELETE, rsfs_pkg::MODE_READ: begin
						if (idx_range) begin
							st_q <= rsfs_pkg::ST_RANGE;
						end
					end
					rsfs_pkg::MODE_RECENT: begin
						if (idx_q >= 8'(rused_q)) begin
							st_q <= rsfs_pkg::ST_RANGE;
						end
					end
					default: begin
					end
				endcase
			end
			S_POP: begin
				if (pop_bad) begin
					st_q <= rsfs_pkg::ST_FULL;
				end else begin
					slot_q <= fs_rd;
				end
			end
			S_STORE: begin
				rout_q <= rec_q;
			end
			S_CHECK: begin
				if (del_erased) begin
					st_q <= rsfs_pkg::ST_ERASED;
				end else if (fs_full) begin
					st_q <= rsfs_pkg::ST_STACK_FULL;
				end else begin
					slot_q <= idx_q[SW-1:0];
					rout_q <= rsfs_pkg::ERASED_WORD;
				end
			end
			S_RDATA: begin
				slot_q <= idx_q[SW-1:0];
				rout_q <= vld_q[idx_q[SW-1:0]] ? rec_rd : rsfs_pkg::ERASED_WORD;
			end
			S_RLIST: begin
				slot_q <= rl_rd;
				if (!rl_slot_ok) begin
					rout_q <= rsfs_pkg::ERASED_WORD;
				end
			end
			S_RREC: begin
				rout_q <= rec_live ? rec_rd : rsfs_pkg::ERASED_WORD;
			end
			default: begin
			end
		endcase
		if (load) begin
			rsp_q.status       <= st_q;
			rsp_q.slot_used    <= slot8[4:0];
			rsp_q.record_out   <= rout_q;
			rsp_q.live_count   <= live9[5:0];
			rsp_q.recent_count <= 5'(rused_q);
		end
	end

	assign live9 = 9'(live_q);
	assign slot8 = 8'(slot_q);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the record slot store with free stack and recent-slots list.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NSLOTS     = rsfs_pkg::SLOT_COUNT_DEF;
	localparam int unsigned FREE_DEPTH = rsfs_pkg::FREE_STACK_DEPTH_DEF;
	localparam int unsigned LIST_DEPTH = rsfs_pkg::RECENT_DEPTH_DEF;
	localparam int unsigned IDLE_LIMIT = 5000;
	localparam int unsigned TAIL_WAIT  = 30;
	localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	rsfs_pkg::cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsfs_pkg::rsp_t rsp;

	record_slot_store_with_free_stack_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// Commands waiting to be sent, results waiting to arrive
	rsfs_pkg::cmd_t queued_cmds[$];
	rsfs_pkg::rsp_t awaited_results[$];

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned cmds_sent = 0;
	int unsigned results_seen = 0;
	int unsigned fail_count = 0;
	int unsigned idle_cycles = 0;
	int unsigned status_tally[5];

	// Shadow copy of the store
	logic [63:0] shadow_mem [NSLOTS];
	logic [4:0]  shadow_free [FREE_DEPTH];
	logic [4:0]  shadow_recent [LIST_DEPTH];
	int unsigned shadow_free_cnt;
	int unsigned shadow_live;
	int unsigned shadow_recent_cnt;

	function automatic void clear_shadow();
		for (int k = 0; k < NSLOTS; k++)
			shadow_mem[k] = ALL_ONES;
		shadow_free_cnt = 0;
		shadow_live = 0;
		shadow_recent_cnt = 0;
	endfunction

	// Apply one command to the shadow store and return the result it must give
	function automatic rsfs_pkg::rsp_t slot_store_step(input rsfs_pkg::cmd_t c);
		rsfs_pkg::rsp_t r;
		int unsigned slot;
		int unsigned pos;
		bit found;
		r = '0;
		r.status = rsfs_pkg::ST_OK;
		case (c.mode)
		rsfs_pkg::MODE_STORE: begin
			if (shadow_live >= NSLOTS) begin
				r.status = rsfs_pkg::ST_FULL;
			end else begin
				if (shadow_free_cnt > 0) begin
					shadow_free_cnt--;
					slot = shadow_free[shadow_free_cnt];
				end else begin
					slot = shadow_live;
				end
				shadow_mem[slot] = c.record_in;
				// append, dropping the oldest when the list is full
				if (shadow_recent_cnt < LIST_DEPTH) begin
					shadow_recent[shadow_recent_cnt] = 5'(slot);
					shadow_recent_cnt++;
				end else begin
					for (int k = 0; k + 1 < LIST_DEPTH; k++)
						shadow_recent[k] = shadow_recent[k + 1];
					shadow_recent[LIST_DEPTH - 1] = 5'(slot);
				end
				shadow_live++;
				r.slot_used = 5'(slot);
				r.record_out = c.record_in;
			end
		end
		rsfs_pkg::MODE_DELETE: begin
			if (c.slot_index >= NSLOTS) begin
				r.status = rsfs_pkg::ST_RANGE;
			end else if (shadow_mem[c.slot_index][7:0] == 8'hFF) begin
				r.status = rsfs_pkg::ST_ERASED;
			end else if (shadow_free_cnt >= FREE_DEPTH) begin
				r.status = rsfs_pkg::ST_STACK_FULL;
			end else begin
				shadow_free[shadow_free_cnt] = 5'(c.slot_index);
				shadow_free_cnt++;
				shadow_mem[c.slot_index] = ALL_ONES;
				if (shadow_live > 0)
					shadow_live--;
				// drop the slot from the list, later entries move down
				found = 1'b0;
				for (pos = 0; pos < shadow_recent_cnt && !found; pos++) begin
					if (shadow_recent[pos] == 5'(c.slot_index))
						found = 1'b1;
				end
				if (found) begin
					for (int k = pos - 1; k + 1 < LIST_DEPTH; k++)
						shadow_recent[k] = shadow_recent[k + 1];
					shadow_recent[LIST_DEPTH - 1] = '0;
					shadow_recent_cnt--;
				end
				r.slot_used = 5'(c.slot_index);
				r.record_out = ALL_ONES;
			end
		end
		rsfs_pkg::MODE_READ: begin
			if (c.slot_index >= NSLOTS) begin
				r.status = rsfs_pkg::ST_RANGE;
			end else begin
				r.slot_used = 5'(c.slot_index);
				r.record_out = shadow_mem[c.slot_index];
			end
		end
		rsfs_pkg::MODE_RESET: clear_shadow();
		rsfs_pkg::MODE_RECENT: begin
			if (c.slot_index >= shadow_recent_cnt) begin
				r.status = rsfs_pkg::ST_RANGE;
			end else begin
				r.slot_used = shadow_recent[c.slot_index];
				r.record_out = shadow_mem[shadow_recent[c.slot_index]];
			end
		end
		default: ;
		endcase
		r.live_count = 6'(shadow_live);
		r.recent_count = 5'(shadow_recent_cnt);
		return r;
	endfunction

	// Compare one arriving result with the oldest expectation
	function automatic void check_result(input rsfs_pkg::rsp_t got);
		rsfs_pkg::rsp_t want;
		if (awaited_results.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: result with none expected: status %0d slot %0d rec %h",
					$realtime, got.status, got.slot_used, got.record_out);
			return;
		end
		want = awaited_results.pop_front();
		results_seen++;
		if (want.status < 5)
			status_tally[want.status]++;
		if (got.status !== want.status || got.slot_used !== want.slot_used ||
			got.record_out !== want.record_out || got.live_count !== want.live_count ||
			got.recent_count !== want.recent_count) begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("%0t: result %0d mismatch", $realtime, results_seen);
				$display("  exp status %0d slot %0d rec %h live %0d recent %0d",
					want.status, want.slot_used, want.record_out,
					want.live_count, want.recent_count);
				$display("  got status %0d slot %0d rec %h live %0d recent %0d",
					got.status, got.slot_used, got.record_out,
					got.live_count, got.recent_count);
			end
		end
	endfunction

	// Command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				awaited_results.push_back(slot_store_step(cmd));
				cmds_sent++;
			end
			// a stalled item is held as it is
			if (!cmd_valid || !cmd_stall) begin
				if (queued_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					cmd_valid <= 1'b1;
					cmd <= queued_cmds.pop_front();
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall)
				check_result(rsp);
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog on cycles with no item moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
				$display("[record_slot_store_with_free_stack_top] ERROR");
				$finish;
			end
		end
	end

	function automatic void push_cmd(input logic [2:0] m, input logic [7:0] idx,
		input logic [63:0] rec);
		rsfs_pkg::cmd_t c;
		c.mode = m;
		c.slot_index = idx;
		c.record_in = rec;
		queued_cmds.push_back(c);
	endfunction

	function automatic logic [63:0] rand_record();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(15))
		0: v = '0;
		1: v = ALL_ONES;
		2: v[7:0] = 8'hFF;
		default: ;
		endcase
		return v;
	endfunction

	// Fill to capacity, fill the free stack to overflow, then refill from it
	function automatic void add_fill_drain();
		logic [7:0] order [NSLOTS];
		logic [7:0] tmp;
		logic [63:0] rec;
		int unsigned j;
		for (int k = 0; k < NSLOTS; k++)
			order[k] = 8'(k);
		for (int k = NSLOTS - 1; k > 0; k--) begin
			j = $urandom_range(k);
			tmp = order[k];
			order[k] = order[j];
			order[j] = tmp;
		end
		push_cmd(rsfs_pkg::MODE_RESET, 8'($urandom), {$urandom, $urandom});
		for (int k = 0; k <= NSLOTS; k++) begin
			rec = {$urandom, $urandom};
			rec[7:0] = 8'($urandom_range(254));
			push_cmd(rsfs_pkg::MODE_STORE, 8'($urandom), rec);
		end
		push_cmd(rsfs_pkg::MODE_RECENT, 8'(LIST_DEPTH - 1), '0);
		for (int k = 0; k <= FREE_DEPTH; k++)
			push_cmd(rsfs_pkg::MODE_DELETE, order[k], {$urandom, $urandom});
		for (int k = 0; k < 4; k++) begin
			push_cmd(rsfs_pkg::MODE_STORE, 8'($urandom), rand_record());
			push_cmd(rsfs_pkg::MODE_RECENT, 8'($urandom_range(LIST_DEPTH)), '0);
			push_cmd(rsfs_pkg::MODE_READ, order[$urandom_range(FREE_DEPTH)], '0);
		end
	endfunction

	// Weighted mix of every command, mostly in range
	function automatic void add_random_mix(input int unsigned n);
		int unsigned pick;
		logic [7:0] idx;
		for (int unsigned k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			idx = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(NSLOTS - 1));
			if (pick < 38)
				push_cmd(rsfs_pkg::MODE_STORE, 8'($urandom), rand_record());
			else if (pick < 62)
				push_cmd(rsfs_pkg::MODE_DELETE, idx, {$urandom, $urandom});
			else if (pick < 76)
				push_cmd(rsfs_pkg::MODE_READ, idx, {$urandom, $urandom});
			else if (pick < 90)
				push_cmd(rsfs_pkg::MODE_RECENT, ($urandom_range(7) == 0) ? 8'($urandom) :
					8'($urandom_range(LIST_DEPTH + 1)), {$urandom, $urandom});
			else if (pick < 93)
				push_cmd(rsfs_pkg::MODE_RESET, 8'($urandom), {$urandom, $urandom});
			else
				push_cmd(3'($urandom_range(7, 5)), 8'($urandom), {$urandom, $urandom});
		end
	endfunction

	// Stimulus and end of run
	initial begin
		int unsigned idle_set [4];
		int unsigned stall_set [4];
		idle_set = '{0, 75, 0, 38};
		stall_set = '{0, 0, 75, 38};
		clear_shadow();
		for (int k = 0; k < 5; k++)
			status_tally[k] = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_set[ph];
			stall_pct = stall_set[ph];
			if (ph == 0) begin
				// reads and deletes on an empty store, out-of-range indexes
				push_cmd(rsfs_pkg::MODE_READ, 8'd0, '0);
				push_cmd(rsfs_pkg::MODE_READ, 8'(NSLOTS - 1), '0);
				push_cmd(rsfs_pkg::MODE_READ, 8'(NSLOTS), '0);
				push_cmd(rsfs_pkg::MODE_READ, 8'hFF, ALL_ONES);
				push_cmd(rsfs_pkg::MODE_RECENT, 8'd0, '0);
				push_cmd(rsfs_pkg::MODE_DELETE, 8'd0, '0);
				push_cmd(rsfs_pkg::MODE_DELETE, 8'hFF, '0);
				push_cmd(rsfs_pkg::MODE_DELETE, 8'(NSLOTS), '0);
				// stores including records that look erased
				push_cmd(rsfs_pkg::MODE_STORE, 8'd0, '0);
				push_cmd(rsfs_pkg::MODE_STORE, 8'hFF, ALL_ONES);
				push_cmd(rsfs_pkg::MODE_STORE, 8'd0, 64'h0123_4567_89AB_CDFF);
				push_cmd(rsfs_pkg::MODE_STORE, 8'd0, 64'hFFFF_FFFF_FFFF_FF00);
				push_cmd(rsfs_pkg::MODE_DELETE, 8'd1, '0);
				push_cmd(rsfs_pkg::MODE_DELETE, 8'd2, '0);
				push_cmd(rsfs_pkg::MODE_DELETE, 8'd0, '0);
				push_cmd(rsfs_pkg::MODE_RECENT, 8'd0, '0);
				push_cmd(rsfs_pkg::MODE_RECENT, 8'd2, '0);
				push_cmd(rsfs_pkg::MODE_RECENT, 8'd3, '0);
				push_cmd(rsfs_pkg::MODE_RECENT, 8'hFF, '0);
				// store takes the freed slot back
				push_cmd(rsfs_pkg::MODE_STORE, 8'd0, 64'hA5A5_5A5A_C3C3_3C3C);
				push_cmd(rsfs_pkg::MODE_READ, 8'd0, '0);
				// unused modes do nothing
				push_cmd(3'd5, 8'd0, '0);
				push_cmd(3'd6, 8'hFF, ALL_ONES);
				push_cmd(3'd7, 8'd3, 64'h1234_5678_9ABC_DEF0);
				push_cmd(rsfs_pkg::MODE_RESET, 8'd0, '0);
				push_cmd(rsfs_pkg::MODE_READ, 8'd3, '0);
			end
			add_fill_drain();
			add_random_mix(30);
			// sender holds off until every result of the phase is back
			while (queued_cmds.size() != 0 || cmd_valid || awaited_results.size() != 0)
				@(negedge clk);
		end

		repeat (TAIL_WAIT) @(posedge clk);
		if (awaited_results.size() != 0) begin
			fail_count++;
			$display("%0d expected results never arrived", awaited_results.size());
		end
		$display("Sent %0d commands and checked %0d results over four idling phases.",
			cmds_sent, results_seen);
		$display("Outcomes: ok %0d, full %0d, erased %0d, stack full %0d, range %0d.",
			status_tally[0], status_tally[1], status_tally[2], status_tally[3],
			status_tally[4]);
		if (fail_count == 0) begin
			$display("[record_slot_store_with_free_stack_top] OK");
		end else begin
			$display("%0d failures", fail_count);
			$display("[record_slot_store_with_free_stack_top] ERROR");
		end
		$finish;
	end

endmodule
